>>> rtl/lpst_pkg.sv
`default_nettype none

package lpst_pkg;

	// Register map, index i at byte address 4*i
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_HALF   = 2'd2,
		REG_THRESH = 2'd3
	} reg_idx_t;

	localparam logic [11:0] RST_WIDTH  = 12'd640;
	localparam logic [11:0] RST_HEIGHT = 12'd480;
	localparam logic [3:0]  RST_HALF   = 4'd2;
	localparam logic [7:0]  RST_THRESH = 8'd20;

	// Coordinates are 11 bits, so frames are limited to 2048 in each direction
	localparam logic [11:0] COORD_LIMIT = 12'd2048;

	// Output queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	// Per-pixel control carried from the counter stage into the stencil
	typedef struct packed {
		logic        judge;
		logic        frame_last;
		logic        left_edge;
		logic [10:0] column;
		logic [10:0] row;
		logic [7:0]  pixel;
	} ctl_t;

	// One result
	typedef struct packed {
		logic        is_line;
		logic [10:0] column;
		logic [10:0] row;
		logic        frame_last;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/lpst_store.sv
`default_nettype none

module lpst_store #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HALF  = 8,
	parameter int SLOT_W    = 4,
	parameter int COL_W     = 11
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_slot,
	input  wire logic [COL_W-1:0]  wr_col,
	input  wire logic [7:0]        wr_data,
	input  wire logic [SLOT_W-1:0] a_slot,
	input  wire logic [COL_W-1:0]  a_col,
	input  wire logic [SLOT_W-1:0] b_slot,
	input  wire logic [COL_W-1:0]  b_col,
	output logic      [7:0]        rd_a,
	output logic      [7:0]        rd_b
);
	import lpst_pkg::*;

	// Line store: 2*MAX_HALF rows of MAX_WIDTH pixels, one write and two reads a cycle.
	// Reads return the old entry when the write hits the same address.
	logic [7:0] mem [2*MAX_HALF][MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot][wr_col] <= wr_data;
		end
		rd_a <= mem[a_slot][a_col];
		rd_b <= mem[b_slot][b_col];
	end

endmodule

`default_nettype wire

>>> rtl/lpst_stencil.sv
`default_nettype none

module lpst_stencil #(
	parameter int MAX_HALF = 8,
	parameter int HW       = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [HW-1:0]  half,
	input  wire logic [7:0]     thresh,
	input  wire logic           valid_s1,
	input  wire lpst_pkg::ctl_t ctl_s1,
	input  wire logic [7:0]     rd_a,
	input  wire logic [7:0]     rd_b,
	output logic                pend_s2,
	output logic                res_valid,
	output lpst_pkg::res_t      res
);
	import lpst_pkg::*;

	localparam int IDX_W = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;

	// a_line: centre-row reads at column x+H (one per pixel)
	// s_line: centre-row value at the pixel's own column
	logic [7:0] a_line_q [MAX_HALF];
	logic [7:0] s_line_q [MAX_HALF];

	logic [IDX_W-1:0] tap;
	logic [7:0]       ctr;
	logic [7:0]       lft;
	logic [7:0]       s_val;

	logic       valid_s2;
	ctl_t       ctl_s2;
	logic [7:0] ctr_s2;
	logic [7:0] lft_s2;
	logic [7:0] rgt_s2;
	logic [7:0] up_s2;
	logic [7:0] dn_s2;

	function automatic logic exceeds(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] t);
		return {2'b00, a} > ({2'b00, b} + {2'b00, t});
	endfunction

	// Tap H back holds the read made H pixels earlier in this row
	assign tap   = IDX_W'(half - HW'(1));
	assign ctr   = a_line_q[tap];
	assign lft   = s_line_q[tap];
	// Left of H the own column comes from port B, else from the delayed A read
	assign s_val = ctl_s1.left_edge ? rd_b : ctr;

	// Shift lines advance once per pixel
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			a_line_q[0] <= rd_a;
			s_line_q[0] <= s_val;
			for (int i = 1; i < MAX_HALF; i++) begin
				a_line_q[i] <= a_line_q[i-1];
				s_line_q[i] <= s_line_q[i-1];
			end
		end
	end

	// Stage 2: operands of judged pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && ctl_s1.judge;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		ctr_s2 <= ctr;
		lft_s2 <= lft;
		rgt_s2 <= rd_a;
		up_s2  <= rd_b;
		dn_s2  <= ctl_s1.pixel;
	end

	// Contrast test, both horizontal or both vertical neighbors
	always_comb begin
		res.is_line    = (exceeds(ctr_s2, lft_s2, thresh) && exceeds(ctr_s2, rgt_s2, thresh)) ||
		                 (exceeds(ctr_s2, up_s2, thresh) && exceeds(ctr_s2, dn_s2, thresh));
		res.column     = ctl_s2.column;
		res.row        = ctl_s2.row;
		res.frame_last = ctl_s2.frame_last;
	end

	assign res_valid = valid_s2;
	assign pend_s2   = valid_s2;

endmodule

`default_nettype wire

>>> rtl/lpst_outq.sv
`default_nettype none

module lpst_outq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire lpst_pkg::res_t                  push_data,
	input  wire logic                            pop,
	output logic                                 valid,
	output lpst_pkg::res_t                       data,
	output logic [lpst_pkg::OUTQ_CNT_W-1:0]      count
);
	import lpst_pkg::*;

	res_t                  buf_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q;
	logic [OUTQ_PTR_W-1:0] rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OUTQ_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OUTQ_CNT_W'(1);
			end
		end
	end

	assign valid = (cnt_q != '0);
	assign data  = buf_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

`default_nettype wire

>>> rtl/line_pixel_stencil_threshold_top.sv
`default_nettype none

// Cross-stencil line detector. Gray pixels enter in raster order, one per clock
// sustained; s_tuser marks the first pixel of a frame. Each pixel is placed in a
// line store of 2*H rows and, when the pixel H rows above it lies at least H from
// every border, that centre is judged against its neighbors at distance H and one
// result leaves on the master side after stage 1, stage 2 and the result queue. The
// rate is set by the line store, which does one write and two reads for every
// pixel; the centre and left neighbor come from shift lines fed by those reads. A
// four-entry result queue decouples the two sides: s_tready drops only when the
// queue plus the results still in the pipeline fill it. Border pixels give no
// result; the last result of a frame carries m_tlast. Registers are to be written
// over the APB port only between frames; the block itself does not enforce this.
module line_pixel_stencil_threshold_top #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HALF  = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Pixel stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] pixel
	input  wire logic        s_tuser,   // frame_start
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [0] is_line, [11:1] column, [22:12] row, [23] zero
	output logic             m_tlast    // frame_last
);
	import lpst_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int SLOT_W = $clog2(2 * MAX_HALF);
	localparam int HW     = $clog2(MAX_HALF + 1);
	localparam int W_LIM  = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

	// Configuration registers
	logic [11:0] cfg_w_q;
	logic [11:0] cfg_h_q;
	logic [3:0]  cfg_half_q;
	logic [7:0]  cfg_thr_q;

	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	// Effective settings
	logic [11:0]   w_eff;
	logic [11:0]   hg_eff;
	logic [HW-1:0] h_eff;

	// Counters
	logic [10:0]       col_q;
	logic [10:0]       row_q;
	logic [SLOT_W-1:0] slot_q;

	// Stage 0
	logic              accept;
	logic [11:0]       xc;
	logic [11:0]       yc;
	logic [11:0]       h12;
	logic [11:0]       xa;
	logic [11:0]       xn;
	logic [11:0]       yn;
	logic [SLOT_W-1:0] sl;
	logic [SLOT_W-1:0] sl_n;
	logic [SLOT_W-1:0] cslot;
	logic [10:0]       col_n;
	logic [10:0]       row_n;
	logic [COL_W-1:0]  a_col;
	logic [SLOT_W-1:0] b_slot;
	ctl_t              ctl0;

	// Stage 1
	logic       valid_s1;
	ctl_t       ctl_s1;
	logic [7:0] rd_a;
	logic [7:0] rd_b;

	logic                  pend_s2;
	logic                  res_valid;
	res_t                  res;
	res_t                  q_data;
	logic [OUTQ_CNT_W-1:0] q_count;
	logic [OUTQ_CNT_W:0]   q_need;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s,
		input logic [HW-1:0] hh);
		return ((32'(s) + 1) >= (2 * 32'(hh))) ? '0 : SLOT_W'(32'(s) + 1);
	endfunction

	// APB register file
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q    <= RST_WIDTH;
			cfg_h_q    <= RST_HEIGHT;
			cfg_half_q <= RST_HALF;
			cfg_thr_q  <= RST_THRESH;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:  cfg_w_q    <= pwdata[11:0];
				REG_HEIGHT: cfg_h_q    <= pwdata[11:0];
				REG_HALF:   cfg_half_q <= pwdata[3:0];
				REG_THRESH: cfg_thr_q  <= pwdata[7:0];
				default:    cfg_thr_q  <= cfg_thr_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:  prdata = 32'(cfg_w_q);
			REG_HEIGHT: prdata = 32'(cfg_h_q);
			REG_HALF:   prdata = 32'(cfg_half_q);
			REG_THRESH: prdata = 32'(cfg_thr_q);
			default:    prdata = '0;
		endcase
	end

	// Clamp settings to what the datapath supports
	always_comb begin
		if (cfg_w_q == '0) begin
			w_eff = 12'd1;
		end else if (32'(cfg_w_q) > W_LIM) begin
			w_eff = 12'(W_LIM);
		end else begin
			w_eff = cfg_w_q;
		end
		if (cfg_h_q == '0) begin
			hg_eff = 12'd1;
		end else if (cfg_h_q > COORD_LIMIT) begin
			hg_eff = COORD_LIMIT;
		end else begin
			hg_eff = cfg_h_q;
		end
		if (cfg_half_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(cfg_half_q) > MAX_HALF) begin
			h_eff = HW'(MAX_HALF);
		end else begin
			h_eff = HW'(cfg_half_q);
		end
	end

	// Stage 0: place the pixel, decide whether its centre is judged, set addresses
	always_comb begin
		h12 = 12'(h_eff);
		xc  = s_tuser ? 12'd0 : {1'b0, col_q};
		yc  = s_tuser ? 12'd0 : {1'b0, row_q};
		sl  = s_tuser ? '0 : slot_q;
		if (xc >= w_eff) begin
			xc = 12'd0;
			yc = yc + 12'd1;
			sl = slot_next(sl, h_eff);
		end
		if (yc >= hg_eff) begin
			yc = 12'd0;
			sl = '0;
		end

		// Slot of the centre row, H rows up
		cslot = (32'(sl) >= 32'(h_eff)) ? SLOT_W'(32'(sl) - 32'(h_eff))
		                                : SLOT_W'(32'(sl) + 32'(h_eff));

		ctl0.judge      = (yc >= {h12[10:0], 1'b0}) && (xc >= h12) && ((xc + h12) < w_eff);
		ctl0.frame_last = ((xc + h12 + 12'd1) == w_eff) && ((yc + 12'd1) == hg_eff);
		ctl0.left_edge  = (xc < h12);
		ctl0.column     = xc[10:0];
		ctl0.row        = 11'(yc - h12);
		ctl0.pixel      = s_tdata;

		// Port A: centre row, H columns right; port B: row 2H up, or centre row at the left edge
		xa     = xc + h12;
		a_col  = (32'(xa) < MAX_WIDTH) ? COL_W'(xa) : '0;
		b_slot = ctl0.left_edge ? cslot : sl;

		// Counters after this pixel
		xn    = xc + 12'd1;
		yn    = yc;
		sl_n  = sl;
		col_n = xn[10:0];
		if (xn >= w_eff) begin
			col_n = '0;
			yn    = yc + 12'd1;
			sl_n  = slot_next(sl, h_eff);
			if (yn >= hg_eff) begin
				yn   = 12'd0;
				sl_n = '0;
			end
		end
		row_n = yn[10:0];
	end

	// Admit a pixel only if its result is sure to find room in the queue
	assign q_need   = {1'b0, q_count} + (OUTQ_CNT_W+1)'(valid_s1 && ctl_s1.judge)
	                  + (OUTQ_CNT_W+1)'(pend_s2);
	assign s_tready = (32'(q_need) <= OUTQ_DEPTH - 1);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				col_q  <= col_n;
				row_q  <= row_n;
				slot_q <= sl_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl0;
	end

	lpst_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HALF  (MAX_HALF),
		.SLOT_W    (SLOT_W),
		.COL_W     (COL_W)
	) u_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_slot (sl),
		.wr_col  (COL_W'(xc)),
		.wr_data (s_tdata),
		.a_slot  (cslot),
		.a_col   (a_col),
		.b_slot  (b_slot),
		.b_col   (COL_W'(xc)),
		.rd_a    (rd_a),
		.rd_b    (rd_b)
	);

	lpst_stencil #(
		.MAX_HALF (MAX_HALF),
		.HW       (HW)
	) u_stencil (
		.clk       (clk),
		.arst_n    (arst_n),
		.half      (h_eff),
		.thresh    (cfg_thr_q),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.pend_s2   (pend_s2),
		.res_valid (res_valid),
		.res       (res)
	);

	lpst_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (m_tvalid && m_tready),
		.valid     (m_tvalid),
		.data      (q_data),
		.count     (q_count)
	);

	assign m_tdata = {1'b0, q_data.row, q_data.column, q_data.is_line};
	assign m_tlast = q_data.frame_last;

endmodule

`default_nettype wire

>>> rtl/lpst_check.sv
`default_nettype none

module lpst_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tlast
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("result changed while stalled");

	// Judged centres never lie on column 0 or row 0
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[11:1] != 11'd0) && (m_tdata[22:12] != 11'd0)))
		else $error("result on a border pixel");

	// Input stalls only while results are backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty result queue");

	// A result into an empty queue follows a pixel taken earlier, through the stage 1, stage 2 and queue registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
		else $error("result without matching request");

endmodule

bind line_pixel_stencil_threshold_top lpst_check u_check (.*);

`default_nettype wire
